>>> design/instruction_class_decoder_assert.svh
// ----------------------------------------------------------------------------
// instruction_class_decoder_assert.svh
// assertion macros for the instruction class decoder checker
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_CLASS_DECODER_ASSERT_SVH
`define INSTRUCTION_CLASS_DECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define ICD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ICD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define ICD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/icd_pkg.sv
// ----------------------------------------------------------------------------
// icd_pkg
// types and constants shared by the instruction class decoder
// ----------------------------------------------------------------------------
package icd_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CLASS_W = 7;

  // words handed to the handler for the implied-r0 program memory loads
  localparam logic [WORD_W-1:0] LPM_R0_WORD  = 16'h9004;
  localparam logic [WORD_W-1:0] ELPM_R0_WORD = 16'h9006;

  // numbered in order of first appearance in the decode tree
  typedef enum logic [CLASS_W-1:0] {
    CLS_NOP, CLS_MOVW, CLS_MULS, CLS_MULSU, CLS_FMUL, CLS_FMULS, CLS_FMULSU,
    CLS_CPC, CLS_CP, CLS_SBC, CLS_SUB, CLS_ADC, CLS_ADD, CLS_CPSE,
    CLS_AND, CLS_EOR, CLS_OR, CLS_MOV, CLS_CPI, CLS_SBCI, CLS_SUBI,
    CLS_ORI, CLS_ANDI, CLS_STD, CLS_LDD, CLS_STS, CLS_ST_Y, CLS_ST_Z,
    CLS_PUSH, CLS_ST_X, CLS_LDS, CLS_LD_Y, CLS_LD_Z, CLS_POP, CLS_LD_X,
    CLS_LPM, CLS_ELPM, CLS_COM, CLS_NEG, CLS_SWAP, CLS_INC, CLS_ASR,
    CLS_LSR, CLS_ROR, CLS_RET, CLS_RETI, CLS_SLEEP, CLS_SPM, CLS_BCLR,
    CLS_BSET, CLS_ICALL, CLS_IJMP, CLS_EICALL, CLS_EIJMP, CLS_DEC, CLS_JMP,
    CLS_CALL, CLS_ADIW, CLS_SBIW, CLS_SBI, CLS_CBI, CLS_SBIS, CLS_SBIC,
    CLS_MUL, CLS_IN, CLS_OUT, CLS_RJMP, CLS_RCALL, CLS_LDI, CLS_BRANCH,
    CLS_BLD, CLS_BST, CLS_SBRS, CLS_SBRC
  } inst_class_t;

  typedef struct packed {
    inst_class_t       cls;
    logic              invalid;
    logic [WORD_W-1:0] word;
  } decode_t;

endpackage

>>> design/icd_decode.sv
// ----------------------------------------------------------------------------
// icd_decode
// priority decode tree: opcode word to instruction class and handler word
// ----------------------------------------------------------------------------
module icd_decode (
  input  logic [icd_pkg::WORD_W-1:0] word,
  output icd_pkg::decode_t           result
);

  logic [7:0]            h;
  logic [7:0]            l;
  logic [3:0]            n;
  logic [7:0]            g;
  logic                  bad;
  icd_pkg::inst_class_t  cls;
  logic [icd_pkg::WORD_W-1:0] hw;

  assign h = word[15:8];
  assign l = word[7:0];
  assign n = word[3:0];
  assign g = {h[7:2], 2'b00};

  always_comb begin
    bad = 1'b0;
    cls = icd_pkg::CLS_NOP;
    hw  = word;
    if (h[7:2] == 6'b000000) begin
      if (word == '0) begin
        cls = icd_pkg::CLS_NOP;
      end else if (h == 8'h01) begin
        cls = icd_pkg::CLS_MOVW;
      end else if (h == 8'h02) begin
        cls = icd_pkg::CLS_MULS;
      end else if (h == 8'h03) begin
        case ({l[7], l[3]})
          2'b00:   cls = icd_pkg::CLS_MULSU;
          2'b01:   cls = icd_pkg::CLS_FMUL;
          2'b10:   cls = icd_pkg::CLS_FMULS;
          default: cls = icd_pkg::CLS_FMULSU;
        endcase
      end else begin
        bad = 1'b1;
      end
    end else if (h[7:6] == 2'b00) begin
      if (h[7:5] == 3'b000) begin
        case (g)
          8'h04:   cls = icd_pkg::CLS_CPC;
          8'h14:   cls = icd_pkg::CLS_CP;
          8'h08:   cls = icd_pkg::CLS_SBC;
          8'h18:   cls = icd_pkg::CLS_SUB;
          8'h1c:   cls = icd_pkg::CLS_ADC;
          8'h0c:   cls = icd_pkg::CLS_ADD;
          8'h10:   cls = icd_pkg::CLS_CPSE;
          default: bad = 1'b1;
        endcase
      end else begin
        case (g)
          8'h20:   cls = icd_pkg::CLS_AND;
          8'h24:   cls = icd_pkg::CLS_EOR;
          8'h28:   cls = icd_pkg::CLS_OR;
          8'h2c:   cls = icd_pkg::CLS_MOV;
          default: cls = icd_pkg::CLS_CPI;
        endcase
      end
    end else if (h[7:6] == 2'b01) begin
      case (h[7:4])
        4'h4:    cls = icd_pkg::CLS_SBCI;
        4'h5:    cls = icd_pkg::CLS_SUBI;
        4'h6:    cls = icd_pkg::CLS_ORI;
        default: cls = icd_pkg::CLS_ANDI;
      endcase
    end else if ((h & 8'hd0) == 8'h80) begin
      cls = h[1] ? icd_pkg::CLS_STD : icd_pkg::CLS_LDD;
    end else if (h[7:2] == 6'b100100) begin
      // loose sub-decode: only the listed low-nibble bits are tested
      if (h[1]) begin
        if (n == 4'h0)                  cls = icd_pkg::CLS_STS;
        else if (l[3:2] == 2'b10)       cls = icd_pkg::CLS_ST_Y;
        else if (l[3:2] == 2'b00)       cls = icd_pkg::CLS_ST_Z;
        else if (n == 4'hf)             cls = icd_pkg::CLS_PUSH;
        else if (n >= 4'hc)             cls = icd_pkg::CLS_ST_X;
        else                            bad = 1'b1;
      end else begin
        if (n == 4'h0)                  cls = icd_pkg::CLS_LDS;
        else if (l[3:2] == 2'b10)       cls = icd_pkg::CLS_LD_Y;
        else if (l[3:2] == 2'b00)       cls = icd_pkg::CLS_LD_Z;
        else if (n == 4'hf)             cls = icd_pkg::CLS_POP;
        else if (n >= 4'hc)             cls = icd_pkg::CLS_LD_X;
        else if (l[3:1] == 3'b010)      cls = icd_pkg::CLS_LPM;
        else if (l[3:1] == 3'b011)      cls = icd_pkg::CLS_ELPM;
        else                            bad = 1'b1;
      end
    end else if (h[7:1] == 7'b1001010) begin
      if (!l[3]) begin
        case (n)
          4'h0:    cls = icd_pkg::CLS_COM;
          4'h1:    cls = icd_pkg::CLS_NEG;
          4'h2:    cls = icd_pkg::CLS_SWAP;
          4'h3:    cls = icd_pkg::CLS_INC;
          4'h5:    cls = icd_pkg::CLS_ASR;
          4'h6:    cls = icd_pkg::CLS_LSR;
          4'h7:    cls = icd_pkg::CLS_ROR;
          default: bad = 1'b1;
        endcase
      end else if (h == 8'h95 && n == 4'h8) begin
        if (l == 8'h08) begin
          cls = icd_pkg::CLS_RET;
        end else if (l == 8'h18) begin
          cls = icd_pkg::CLS_RETI;
        end else if (l == 8'h88) begin
          cls = icd_pkg::CLS_SLEEP;
        end else if (l == 8'hc8) begin
          cls = icd_pkg::CLS_LPM;
          hw  = icd_pkg::LPM_R0_WORD;
        end else if (l == 8'hd8) begin
          cls = icd_pkg::CLS_ELPM;
          hw  = icd_pkg::ELPM_R0_WORD;
        end else if ((l & 8'hef) == 8'he8) begin
          cls = icd_pkg::CLS_SPM;
        end else begin
          bad = 1'b1;
        end
      end else if (!h[0] && n == 4'h8) begin
        cls = l[7] ? icd_pkg::CLS_BCLR : icd_pkg::CLS_BSET;
      end else if (l == 8'h09) begin
        cls = h[0] ? icd_pkg::CLS_ICALL : icd_pkg::CLS_IJMP;
      end else if (l == 8'h19) begin
        cls = h[0] ? icd_pkg::CLS_EICALL : icd_pkg::CLS_EIJMP;
      end else if (n == 4'ha) begin
        cls = icd_pkg::CLS_DEC;
      end else if (l[3:1] == 3'b110) begin
        cls = icd_pkg::CLS_JMP;
      end else if (l[3:1] == 3'b111) begin
        cls = icd_pkg::CLS_CALL;
      end else begin
        bad = 1'b1;
      end
    end else if (h[7:4] == 4'h9) begin
      case (h)
        8'h96:   cls = icd_pkg::CLS_ADIW;
        8'h97:   cls = icd_pkg::CLS_SBIW;
        8'h9a:   cls = icd_pkg::CLS_SBI;
        8'h98:   cls = icd_pkg::CLS_CBI;
        8'h9b:   cls = icd_pkg::CLS_SBIS;
        8'h99:   cls = icd_pkg::CLS_SBIC;
        default: cls = icd_pkg::CLS_MUL;
      endcase
    end else if (h[7:3] == 5'b10110) begin
      cls = icd_pkg::CLS_IN;
    end else if (h[7:3] == 5'b10111) begin
      cls = icd_pkg::CLS_OUT;
    end else if (h[7:4] == 4'hc) begin
      cls = icd_pkg::CLS_RJMP;
    end else if (h[7:4] == 4'hd) begin
      cls = icd_pkg::CLS_RCALL;
    end else if (h[7:4] == 4'he) begin
      cls = icd_pkg::CLS_LDI;
    end else if (h[7:3] == 5'b11110) begin
      cls = icd_pkg::CLS_BRANCH;
    end else if (h[7:1] == 7'b1111100) begin
      cls = icd_pkg::CLS_BLD;
    end else if (h[7:1] == 7'b1111101) begin
      cls = icd_pkg::CLS_BST;
    end else if (h[7:1] == 7'b1111111) begin
      cls = icd_pkg::CLS_SBRS;
    end else if (h[7:1] == 7'b1111110) begin
      cls = icd_pkg::CLS_SBRC;
    end else begin
      bad = 1'b1;
    end
  end

  // unassigned encodings report class zero and pass the fetched word
  always_comb begin
    result.invalid = bad;
    result.cls     = bad ? icd_pkg::CLS_NOP : cls;
    result.word    = bad ? word : hw;
  end

endmodule

>>> design/instruction_class_decoder.sv
// ----------------------------------------------------------------------------
// instruction_class_decoder
// classifies one fetched 16-bit opcode per cycle into its instruction class
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  in       | in_valid/in_ready  | instruction_word
//  out      | out_valid/out_ready| inst_class, invalid, handler_word
//
//  one item per cycle unless stalled; input register, decode, result
//  register. reset empties both stages. a stalled result holds in the
//  result register while an empty input register takes a new transfer;
//  in_ready drops only when both stages are full and out_ready is low.
// ----------------------------------------------------------------------------
module instruction_class_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [icd_pkg::WORD_W-1:0]    instruction_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [icd_pkg::CLASS_W-1:0]   inst_class,
  output logic                          invalid,
  output logic [icd_pkg::WORD_W-1:0]    handler_word
);

  logic                       s1_valid;
  logic [icd_pkg::WORD_W-1:0] s1_word;
  logic                       s1_take;
  icd_pkg::decode_t           dec;

  assign s1_take  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_take;

  icd_decode u_decode (
    .word   (s1_word),
    .result (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_take)  out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_word <= instruction_word;
    if (s1_valid && s1_take) begin
      inst_class   <= dec.cls;
      invalid      <= dec.invalid;
      handler_word <= dec.word;
    end
  end

endmodule

>>> design/icd_checker.sv
// ----------------------------------------------------------------------------
// icd_checker
// port-level checks on the instruction class decoder
// ----------------------------------------------------------------------------
`include "instruction_class_decoder_assert.svh"

module icd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [icd_pkg::WORD_W-1:0]  instruction_word,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [icd_pkg::CLASS_W-1:0] inst_class,
  input logic                        invalid,
  input logic [icd_pkg::WORD_W-1:0]  handler_word
);

  logic                                    stall;
  logic                                    implied_word;
  logic [icd_pkg::CLASS_W+icd_pkg::WORD_W:0] result_bits;

  assign stall        = out_valid && !out_ready;
  assign implied_word = (handler_word == 16'h95c8) || (handler_word == 16'h95d8);
  assign result_bits  = {inst_class, invalid, handler_word};

  // an invalid encoding always reports class zero
  `ICD_ASSERT_IMP(a_invalid_class, out_valid && invalid, inst_class == '0, "invalid with class")

  // class numbers stop at the last entry of the tree
  `ICD_ASSERT_IMP(a_class_range, out_valid, inst_class <= 7'd73, "class out of range")

  // implied-r0 loads must be rewritten before reaching the handler
  `ICD_ASSERT_IMP(a_implied_rewrite, out_valid, !implied_word, "implied load not rewritten")

  `ICD_ASSERT_NXT(a_out_hold, stall, out_valid && $stable(result_bits), "result changed")

  `ICD_ASSERT_RST(a_reset_empty, rst, !out_valid, "result after reset")

endmodule

bind instruction_class_decoder icd_checker u_icd_checker (.*);
